@@ hdl/csl_pkg.sv @@
`timescale 1ns / 1ps

package csl_pkg;

  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int OUT_DEPTH = 4;

  // Token kinds
  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_UINT   = 6'd1;
  localparam logic [5:0] K_KW0    = 6'd2;
  localparam logic [5:0] K_PLUS   = 6'd15;
  localparam logic [5:0] K_MINUS  = 6'd16;
  localparam logic [5:0] K_MULT   = 6'd17;
  localparam logic [5:0] K_DIV    = 6'd18;
  localparam logic [5:0] K_LESS   = 6'd19;
  localparam logic [5:0] K_LEQ    = 6'd20;
  localparam logic [5:0] K_GREAT  = 6'd21;
  localparam logic [5:0] K_GEQ    = 6'd22;
  localparam logic [5:0] K_ASSIGN = 6'd23;
  localparam logic [5:0] K_EQUAL  = 6'd24;
  localparam logic [5:0] K_NEQ    = 6'd25;
  localparam logic [5:0] K_CHAR   = 6'd26;
  localparam logic [5:0] K_STRING = 6'd27;
  localparam logic [5:0] K_LPAR   = 6'd28;
  localparam logic [5:0] K_RPAR   = 6'd29;
  localparam logic [5:0] K_LBRACK = 6'd30;
  localparam logic [5:0] K_RBRACK = 6'd31;
  localparam logic [5:0] K_LBRACE = 6'd32;
  localparam logic [5:0] K_RBRACE = 6'd33;
  localparam logic [5:0] K_COMMA  = 6'd34;
  localparam logic [5:0] K_SEMI   = 6'd35;
  localparam logic [5:0] K_COLON  = 6'd36;
  localparam logic [5:0] K_END    = 6'd37;
  localparam logic [5:0] K_ERROR  = 6'd38;

  // Error codes
  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_ILLEGAL    = 3'd1;
  localparam logic [2:0] E_LEAD_ZERO  = 3'd2;
  localparam logic [2:0] E_BAD_CHAR   = 3'd3;
  localparam logic [2:0] E_CHAR_OPEN  = 3'd4;
  localparam logic [2:0] E_STR_OPEN   = 3'd5;
  localparam logic [2:0] E_LONE_BANG  = 3'd6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam int NUM_KW = 13;
  localparam int PREFIX_LEN = 7;

  // First byte of an identifier sits at index 0.
  typedef logic [0:PREFIX_LEN-1][7:0] word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } res_t;

  function automatic word_t kw_word(input logic [3:0] k);
    word_t w;
    begin
      case (k)
        4'd0:    w = {"const", 16'h0};
        4'd1:    w = {"int", 32'h0};
        4'd2:    w = {"char", 24'h0};
        4'd3:    w = {"void", 24'h0};
        4'd4:    w = {"main", 24'h0};
        4'd5:    w = {"if", 40'h0};
        4'd6:    w = {"switch", 8'h0};
        4'd7:    w = {"case", 24'h0};
        4'd8:    w = "default";
        4'd9:    w = {"scanf", 16'h0};
        4'd10:   w = {"printf", 8'h0};
        4'd11:   w = {"return", 8'h0};
        4'd12:   w = {"while", 16'h0};
        default: w = '0;
      endcase
      return w;
    end
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] n;
    begin
      case (k)
        4'd0:    n = 3'd5;
        4'd1:    n = 3'd3;
        4'd2:    n = 3'd4;
        4'd3:    n = 3'd4;
        4'd4:    n = 3'd4;
        4'd5:    n = 3'd2;
        4'd6:    n = 3'd6;
        4'd7:    n = 3'd4;
        4'd8:    n = 3'd7;
        4'd9:    n = 3'd5;
        4'd10:   n = 3'd6;
        4'd11:   n = 3'd6;
        4'd12:   n = 3'd5;
        default: n = 3'd0;
      endcase
      return n;
    end
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [2:0] err,
                                  input logic [15:0] len);
    tok_t t;
    begin
      t.kind = kind;
      t.err  = err;
      t.len  = len;
      return t;
    end
  endfunction

endpackage

@@ hdl/c_subset_lexer.sv @@
`timescale 1ns / 1ps

// Path: a byte accepted on the input is registered in the scan stage, scanned there, and its
// tokens are registered in the result queue, whose head entry drives the out_ ports.
// Throughput: one byte per cycle while the queue has room for two entries; a byte that yields
// two tokens needs two output transfers, buffered by a 4-entry result queue.
// Reset (rst_n low, synchronous): scanner idle, line count one, queue and stage empty,
// halt flag cleared.
module c_subset_lexer import csl_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_token_length,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_LT, M_GT, M_EQ, M_BANG, M_CH1, M_CH2, M_STR
  } mode_t;

  localparam int QW = $clog2(OUT_DEPTH);

  mode_t                   mode_r, mode_nxt;
  word_t                   prefix_r, prefix_nxt;
  logic [LENGTH_WIDTH-1:0] cnt_r, cnt_nxt, cnt_bump;
  logic [15:0]             line_r, line_nxt;
  logic                    fdz_r, fdz_nxt;
  logic                    halt_r, halt_nxt;

  logic       s_v_r, s_v_nxt;
  logic [7:0] s_byte_r;
  logic       in_fire, proc, pop;

  res_t       q_r [OUT_DEPTH];
  res_t       q_nxt [OUT_DEPTH];
  logic [QW:0] qcnt_r, qcnt_nxt, qbase;

  tok_t       a_tok, b_tok;
  logic       a_v, b_v, do_start;
  logic [5:0] word_kind;
  logic [7:0] c;
  res_t       r0, r1;

  assign c        = s_byte_r;
  assign proc     = s_v_r && (qcnt_r <= (QW+1)'(OUT_DEPTH - 2));
  assign in_ready = !s_v_r || proc;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (qcnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign cnt_bump  = (&cnt_r) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    word_kind = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cnt_r == LENGTH_WIDTH'(kw_len(4'(k))) && prefix_r == kw_word(4'(k))) begin
        word_kind = 6'(K_KW0 + 6'(k));
      end
    end
  end

  // One scan step: the first phase finishes the pending token, the second phase
  // starts a new token from the same byte when lookahead ended the old one or none was pending.
  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    cnt_nxt    = cnt_r;
    line_nxt   = line_r;
    fdz_nxt    = fdz_r;
    halt_nxt   = halt_r;
    a_v        = 1'b0;
    b_v        = 1'b0;
    a_tok      = mk_tok(K_IDENT, E_NONE, 16'd0);
    b_tok      = mk_tok(K_IDENT, E_NONE, 16'd0);
    do_start   = 1'b0;
    if (!halt_r) begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (cnt_r < LENGTH_WIDTH'(PREFIX_LEN)) begin
              prefix_nxt[cnt_r[2:0]] = c;
            end
            cnt_nxt = cnt_bump;
          end else begin
            a_v      = 1'b1;
            a_tok    = mk_tok(word_kind, E_NONE, 16'(cnt_r));
            do_start = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            cnt_nxt = cnt_bump;
          end else if (fdz_r && cnt_r > LENGTH_WIDTH'(1)) begin
            a_v      = 1'b1;
            a_tok    = mk_tok(K_ERROR, E_LEAD_ZERO, 16'd0);
            halt_nxt = 1'b1;
            mode_nxt = M_IDLE;
          end else begin
            a_v      = 1'b1;
            a_tok    = mk_tok(K_UINT, E_NONE, 16'(cnt_r));
            do_start = 1'b1;
          end
        end
        M_LT, M_GT, M_EQ: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_tok.len = 16'd2;
            case (mode_r)
              M_LT:    a_tok.kind = K_LEQ;
              M_GT:    a_tok.kind = K_GEQ;
              default: a_tok.kind = K_EQUAL;
            endcase
            mode_nxt = M_IDLE;
          end else begin
            a_tok.len = 16'd1;
            case (mode_r)
              M_LT:    a_tok.kind = K_LESS;
              M_GT:    a_tok.kind = K_GREAT;
              default: a_tok.kind = K_ASSIGN;
            endcase
            do_start = 1'b1;
          end
        end
        M_BANG: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_tok    = mk_tok(K_NEQ, E_NONE, 16'd2);
          end else begin
            a_tok    = mk_tok(K_ERROR, E_LONE_BANG, 16'd0);
            halt_nxt = 1'b1;
          end
          mode_nxt = M_IDLE;
        end
        M_CH1: begin
          if (is_alpha(c) || is_digit(c) || c inside {"+", "-", "*", "/"}) begin
            cnt_nxt  = LENGTH_WIDTH'(2);
            mode_nxt = M_CH2;
          end else begin
            a_v      = 1'b1;
            a_tok    = mk_tok(K_ERROR, E_BAD_CHAR, 16'd0);
            halt_nxt = 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        M_CH2: begin
          a_v = 1'b1;
          if (c == CH_SQUOTE) begin
            a_tok    = mk_tok(K_CHAR, E_NONE, 16'd3);
          end else begin
            a_tok    = mk_tok(K_ERROR, E_CHAR_OPEN, 16'd0);
            halt_nxt = 1'b1;
          end
          mode_nxt = M_IDLE;
        end
        M_STR: begin
          if (c == CH_DQUOTE) begin
            cnt_nxt  = cnt_bump;
            a_v      = 1'b1;
            a_tok    = mk_tok(K_STRING, E_NONE, 16'(cnt_bump));
            mode_nxt = M_IDLE;
          end else if (c inside {[8'd32:8'd126]}) begin
            cnt_nxt = cnt_bump;
          end else begin
            a_v      = 1'b1;
            a_tok    = mk_tok(K_ERROR, E_STR_OPEN, 16'd0);
            halt_nxt = 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        mode_nxt = M_IDLE;
        if (c inside {" ", CH_TAB, CH_LF}) begin
          if (c == CH_LF && line_r != 16'hFFFF) begin
            line_nxt = line_r + 16'd1;
          end
        end else if (is_alpha(c)) begin
          prefix_nxt    = '0;
          prefix_nxt[0] = c;
          cnt_nxt       = LENGTH_WIDTH'(1);
          mode_nxt      = M_IDENT;
        end else if (is_digit(c)) begin
          cnt_nxt  = LENGTH_WIDTH'(1);
          fdz_nxt  = (c == "0");
          mode_nxt = M_NUM;
        end else begin
          case (c)
            "<":       mode_nxt = M_LT;
            ">":       mode_nxt = M_GT;
            "=":       mode_nxt = M_EQ;
            "!":       mode_nxt = M_BANG;
            CH_SQUOTE: begin
              cnt_nxt  = LENGTH_WIDTH'(1);
              mode_nxt = M_CH1;
            end
            CH_DQUOTE: begin
              cnt_nxt  = LENGTH_WIDTH'(1);
              mode_nxt = M_STR;
            end
            "+": begin b_v = 1'b1; b_tok = mk_tok(K_PLUS,   E_NONE, 16'd1); end
            "-": begin b_v = 1'b1; b_tok = mk_tok(K_MINUS,  E_NONE, 16'd1); end
            "*": begin b_v = 1'b1; b_tok = mk_tok(K_MULT,   E_NONE, 16'd1); end
            "/": begin b_v = 1'b1; b_tok = mk_tok(K_DIV,    E_NONE, 16'd1); end
            "(": begin b_v = 1'b1; b_tok = mk_tok(K_LPAR,   E_NONE, 16'd1); end
            ")": begin b_v = 1'b1; b_tok = mk_tok(K_RPAR,   E_NONE, 16'd1); end
            "[": begin b_v = 1'b1; b_tok = mk_tok(K_LBRACK, E_NONE, 16'd1); end
            "]": begin b_v = 1'b1; b_tok = mk_tok(K_RBRACK, E_NONE, 16'd1); end
            "{": begin b_v = 1'b1; b_tok = mk_tok(K_LBRACE, E_NONE, 16'd1); end
            "}": begin b_v = 1'b1; b_tok = mk_tok(K_RBRACE, E_NONE, 16'd1); end
            ",": begin b_v = 1'b1; b_tok = mk_tok(K_COMMA,  E_NONE, 16'd1); end
            ";": begin b_v = 1'b1; b_tok = mk_tok(K_SEMI,   E_NONE, 16'd1); end
            ":": begin b_v = 1'b1; b_tok = mk_tok(K_COLON,  E_NONE, 16'd1); end
            CH_NUL: begin
              b_v      = 1'b1;
              b_tok    = mk_tok(K_END, E_NONE, 16'd0);
              halt_nxt = 1'b1;
            end
            default: begin
              b_v      = 1'b1;
              b_tok    = mk_tok(K_ERROR, E_ILLEGAL, 16'd0);
              halt_nxt = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Pack the step's tokens into queue entries; the last one carries the run mark.
  always_comb begin
    r0.kind = a_v ? a_tok.kind : b_tok.kind;
    r0.err  = a_v ? a_tok.err  : b_tok.err;
    r0.len  = a_v ? a_tok.len  : b_tok.len;
    r0.line = line_r;
    r0.last = !(a_v && b_v);
    r1.kind = b_tok.kind;
    r1.err  = b_tok.err;
    r1.len  = b_tok.len;
    r1.line = line_r;
    r1.last = 1'b1;
  end

  // Result queue: entry 0 is the head, entries shift down on a pop.
  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    qbase    = qcnt_r - (QW+1)'(pop);
    qcnt_nxt = qbase;
    if (proc && (a_v || b_v)) begin
      q_nxt[qbase[QW-1:0]] = r0;
      qcnt_nxt             = qbase + (QW+1)'(1);
      if (a_v && b_v) begin
        q_nxt[QW'(qbase[QW-1:0] + 1'b1)] = r1;
        qcnt_nxt                          = qbase + (QW+1)'(2);
      end
    end
    s_v_nxt = in_fire ? 1'b1 : (proc ? 1'b0 : s_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      prefix_r <= '0;
      cnt_r    <= '0;
      line_r   <= 16'd1;
      fdz_r    <= 1'b0;
      halt_r   <= 1'b0;
      s_v_r    <= 1'b0;
      qcnt_r   <= '0;
    end else begin
      s_v_r  <= s_v_nxt;
      qcnt_r <= qcnt_nxt;
      if (in_fire) begin
        s_byte_r <= in_source_byte;
      end
      for (int i = 0; i < OUT_DEPTH; i++) begin
        q_r[i] <= q_nxt[i];
      end
      if (proc) begin
        mode_r   <= mode_nxt;
        prefix_r <= prefix_nxt;
        cnt_r    <= cnt_nxt;
        line_r   <= line_nxt;
        fdz_r    <= fdz_nxt;
        halt_r   <= halt_nxt;
      end
    end
  end

  assign out_token_kind   = q_r[0].kind;
  assign out_error_code   = q_r[0].err;
  assign out_token_length = q_r[0].len;
  assign out_line_number  = q_r[0].line;
  assign out_last_of_run  = q_r[0].last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= (QW+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && proc) |=> (qcnt_r <= $past(qcnt_r)))
    else $error("halted scanner produced a token");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == K_ERROR || out_token_kind == K_END))
      |-> out_last_of_run)
    else $error("end or error token not last of its run");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line count reached zero");
`endif

endmodule
